// ----- hw/rtl/marq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// marq_pkg
// Shared constants, codes and types of the two-line scrolling marquee.
// ---------------------------------------------------------------------------
package marq_pkg;

  // default geometry
  localparam int NUM_SETS_DEF = 8;
  localparam int MAX_LEN_DEF  = 64;
  localparam int WINDOW_DEF   = 18;

  // input item modes
  localparam logic [1:0] MODE_CHAR = 2'd0;
  localparam logic [1:0] MODE_LEN  = 2'd1;
  localparam logic [1:0] MODE_TICK = 2'd2;

  // register indexes
  localparam logic [1:0] CFG_FRAMES   = 2'd0;
  localparam logic [1:0] CFG_TOP_STEP = 2'd1;
  localparam logic [1:0] CFG_BOT_STEP = 2'd2;

  // register reset values
  localparam logic [15:0] FRAMES_RST   = 16'd80;
  localparam logic [4:0]  TOP_STEP_RST = 5'd1;
  localparam logic [4:0]  BOT_STEP_RST = 5'd2;

  localparam logic [7:0] SPACE_CODE = 8'h20;

  typedef struct packed {
    logic [15:0] frames_per_set;
    logic [4:0]  top_step;
    logic [4:0]  bot_step;
  } marq_cfg_t;

  // side info of one display beat, travels with the store read
  typedef struct packed {
    logic       line;
    logic [4:0] column;
    logic [2:0] set_now;
    logic       last;
    logic       space;
  } beat_meta_t;

endpackage
`default_nettype wire

// ----- hw/rtl/marq_msg_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// marq_msg_ram
// Message character store: one write port, one read port, registered read.
// ---------------------------------------------------------------------------
module marq_msg_ram #(
  parameter int AW = 10
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);

  localparam int DEPTH = 1 << AW;

  logic [7:0] mem [DEPTH];
  logic [7:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- hw/rtl/marq_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// marq_seq
// Frame sequencer: length table, scroll positions, set/frame counters and
// the per-tick walk that issues store reads one column a cycle while the output slot is free.
// ---------------------------------------------------------------------------
module marq_seq #(
  parameter int NUM_SETS_P = marq_pkg::NUM_SETS_DEF,
  parameter int MAX_LEN    = marq_pkg::MAX_LEN_DEF,
  parameter int WINDOW     = marq_pkg::WINDOW_DEF,
  parameter int SW         = (NUM_SETS_P > 1) ? $clog2(NUM_SETS_P) : 1,
  parameter int IW         = $clog2(MAX_LEN),
  parameter int LW         = $clog2(MAX_LEN + 1)
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   tick_go,
  input  wire logic                   len_we,
  input  wire logic [SW-1:0]          len_set,
  input  wire logic                   len_line,
  input  wire logic [LW-1:0]          len_value,
  input  wire marq_pkg::marq_cfg_t    cfg,
  input  wire logic                   slot_free,
  output logic                        busy,
  output logic                        beat_valid,
  output marq_pkg::beat_meta_t        beat_meta,
  output logic                        rd_en,
  output logic [SW+IW:0]              rd_addr
);
  import marq_pkg::*;

  localparam int RW = $clog2(MAX_LEN + 32);
  localparam int CW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam logic [CW-1:0] COL_LAST = CW'(WINDOW - 1);
  localparam logic [SW-1:0] SET_LAST = SW'(NUM_SETS_P - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_LOAD, S_RED, S_EMIT, S_ADV_LOAD, S_ADV_RED, S_FRAME
  } state_t;

  state_t        state_r;
  logic          line_r;
  logic [CW-1:0] col_r;
  logic [RW-1:0] idx_r;
  logic [LW-1:0] len_r;
  logic [IW-1:0] pos_t_r, pos_b_r;
  logic [15:0]   frame_r;
  logic [SW-1:0] set_r;
  logic [LW-1:0] len_tab_r [2*NUM_SETS_P];

  logic [LW-1:0] len_rd;
  logic [RW-1:0] len_ext, idx_inc;
  logic          red_ge, wrap;
  logic [16:0]   cnt_nxt;

  assign len_rd  = len_tab_r[{set_r, line_r}];
  assign len_ext = RW'(len_r);
  assign red_ge  = (len_r != '0) && (idx_r >= len_ext);
  assign idx_inc = idx_r + 1'b1;
  assign wrap    = (idx_inc == len_ext);
  assign cnt_nxt = {1'b0, frame_r} + 17'd1;

  assign busy       = (state_r != S_IDLE);
  assign beat_valid = (state_r == S_EMIT) && slot_free;
  assign rd_en      = beat_valid && (len_r != '0);
  assign rd_addr    = {set_r, line_r, idx_r[IW-1:0]};

  always_comb begin
    beat_meta.line    = line_r;
    beat_meta.column  = 5'(col_r);
    beat_meta.set_now = 3'(set_r);
    beat_meta.last    = line_r && (col_r == COL_LAST);
    beat_meta.space   = (len_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      set_r   <= '0;
      frame_r <= '0;
      pos_t_r <= '0;
      pos_b_r <= '0;
      for (int i = 0; i < 2*NUM_SETS_P; i++) begin
        len_tab_r[i] <= '0;
      end
    end else begin
      if (len_we) begin
        len_tab_r[{len_set, len_line}] <= len_value;
      end
      unique case (state_r)
        S_IDLE: begin
          if (tick_go) begin
            line_r  <= 1'b0;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          len_r   <= len_rd;
          idx_r   <= RW'(line_r ? pos_b_r : pos_t_r);
          col_r   <= '0;
          state_r <= S_RED;
        end
        S_RED: begin
          // bring the start index below the length (position may exceed it)
          if (red_ge) begin
            idx_r <= idx_r - len_ext;
          end else begin
            state_r <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (slot_free) begin
            idx_r <= wrap ? '0 : idx_inc;
            col_r <= col_r + 1'b1;
            if (col_r == COL_LAST) begin
              if (!line_r) begin
                line_r  <= 1'b1;
                state_r <= S_LOAD;
              end else begin
                line_r  <= 1'b0;
                state_r <= S_ADV_LOAD;
              end
            end
          end
        end
        S_ADV_LOAD: begin
          len_r   <= len_rd;
          idx_r   <= line_r ? (RW'(pos_b_r) + RW'(cfg.bot_step))
                            : (RW'(pos_t_r) + RW'(cfg.top_step));
          state_r <= S_ADV_RED;
        end
        S_ADV_RED: begin
          if (red_ge) begin
            idx_r <= idx_r - len_ext;
          end else begin
            if (line_r) begin
              pos_b_r <= (len_r == '0) ? '0 : idx_r[IW-1:0];
              state_r <= S_FRAME;
            end else begin
              pos_t_r <= (len_r == '0) ? '0 : idx_r[IW-1:0];
              line_r  <= 1'b1;
              state_r <= S_ADV_LOAD;
            end
          end
        end
        S_FRAME: begin
          if (cnt_nxt >= {1'b0, cfg.frames_per_set}) begin
            frame_r <= '0;
            set_r   <= (set_r == SET_LAST) ? '0 : set_r + 1'b1;
            pos_t_r <= '0;
            pos_b_r <= '0;
          end else begin
            frame_r <= cnt_nxt[15:0];
          end
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/two_line_scrolling_marquee.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// two_line_scrolling_marquee
// Two-line circular scrolling marquee over several stored message sets.
// ---------------------------------------------------------------------------
// Input channel (in_*): one beat is a character write, a length write or a
// display tick. Writes produce no output beats. A tick produces 2*WINDOW
// output beats: the top line's columns, then the bottom line's, last set
// on the final bottom column. Before each line the modulo reducer brings
// its position below its length by repeated subtraction. Within a line,
// output beats come one per cycle while the receiver does not stall; the
// input side stalls for the whole tick, so items are handled one at a time.
// The first output beat is issued after the length load and the reduction
// of the start index, and shows from the output register.
// Output stall freezes the walk: no store read is issued while the output
// register is full and stalled, so the shown beat holds.
// Reset (synchronous, active low) clears lengths (all lines unset, shown as
// spaces), positions, frame count and set, and loads register defaults. The
// character store is not cleared. Config writes are taken at any cycle.
// ---------------------------------------------------------------------------
module two_line_scrolling_marquee #(
  parameter int NUM_SETS_P = marq_pkg::NUM_SETS_DEF,
  parameter int MAX_LEN    = marq_pkg::MAX_LEN_DEF,
  parameter int WINDOW     = marq_pkg::WINDOW_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_mode,
  input  wire logic        in_line_sel,
  input  wire logic [2:0]  in_set_index,
  input  wire logic [5:0]  in_char_index,
  input  wire logic [7:0]  in_char_value,
  input  wire logic [6:0]  in_length_value,
  // result channel
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_line,
  output logic [4:0]       out_column,
  output logic [7:0]       out_char_code,
  output logic [2:0]       out_set_now,
  output logic             out_last,
  // configuration
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [15:0] cfg_wdata
);
  import marq_pkg::*;

  localparam int SW = (NUM_SETS_P > 1) ? $clog2(NUM_SETS_P) : 1;
  localparam int IW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);
  localparam int AW = SW + 1 + IW;

  marq_cfg_t  cfg_r;
  logic       busy, in_acc, set_ok, char_we, len_we, tick_go;
  logic       slot_free, beat_valid, rd_en;
  beat_meta_t beat_meta, meta_r;
  logic       out_valid_r;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [7:0] rd_data;

  // ---- input decode: writes land in the accept cycle ----
  assign in_stall = busy;
  assign in_acc   = in_valid && !busy;
  assign set_ok   = (32'(in_set_index) < NUM_SETS_P);
  assign char_we  = in_acc && (in_mode == MODE_CHAR) && set_ok
                    && (32'(in_char_index) < MAX_LEN);
  // out-of-range lengths are dropped
  assign len_we   = in_acc && (in_mode == MODE_LEN) && set_ok
                    && (32'(in_length_value) >= WINDOW)
                    && (32'(in_length_value) <= MAX_LEN);
  assign tick_go  = in_acc && (in_mode == MODE_TICK);
  assign wr_addr  = {SW'(in_set_index), in_line_sel, IW'(in_char_index)};

  // ---- configuration registers ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.frames_per_set <= FRAMES_RST;
      cfg_r.top_step       <= TOP_STEP_RST;
      cfg_r.bot_step       <= BOT_STEP_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_FRAMES:   cfg_r.frames_per_set <= cfg_wdata;
        CFG_TOP_STEP: cfg_r.top_step       <= cfg_wdata[4:0];
        CFG_BOT_STEP: cfg_r.bot_step       <= cfg_wdata[4:0];
        default: ;
      endcase
    end
  end

  marq_seq #(
    .NUM_SETS_P(NUM_SETS_P),
    .MAX_LEN   (MAX_LEN),
    .WINDOW    (WINDOW),
    .SW        (SW),
    .IW        (IW),
    .LW        (LW)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .tick_go   (tick_go),
    .len_we    (len_we),
    .len_set   (SW'(in_set_index)),
    .len_line  (in_line_sel),
    .len_value (LW'(in_length_value)),
    .cfg       (cfg_r),
    .slot_free (slot_free),
    .busy      (busy),
    .beat_valid(beat_valid),
    .beat_meta (beat_meta),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr)
  );

  marq_msg_ram #(
    .AW(AW)
  ) u_ram (
    .clk  (clk),
    .we   (char_we),
    .waddr(wr_addr),
    .wdata(in_char_value),
    .re   (rd_en),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // ---- output register ----
  // The store's read register is the char payload; it only moves when a
  // new beat is issued, which needs the slot to be free or draining.
  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (beat_valid) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_valid) begin
      meta_r <= beat_meta;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_line      = meta_r.line;
  assign out_column    = meta_r.column;
  assign out_set_now   = meta_r.set_now;
  assign out_last      = meta_r.last;
  assign out_char_code = meta_r.space ? SPACE_CODE : rd_data;

endmodule
`default_nettype wire

// ----- hw/rtl/marq_chk.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// marq_chk
// Port-level checks of the marquee, bound to the top level.
// ---------------------------------------------------------------------------
module marq_chk #(
  parameter int WINDOW = marq_pkg::WINDOW_DEF
) (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic [1:0]  in_mode,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_line,
  input wire logic [4:0]  out_column,
  input wire logic [7:0]  out_char_code,
  input wire logic [2:0]  out_set_now,
  input wire logic        out_last
);
  import marq_pkg::*;

  // held beat stays put
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char_code)
      && $stable(out_column) && $stable(out_line) && $stable(out_last)
      && $stable(out_set_now))
    else $error("stalled output beat changed");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |-> out_line && (32'(out_column) == WINDOW - 1))
    else $error("frame end flagged off the bottom line's final column");

  a_col: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (32'(out_column) < WINDOW))
    else $error("column beyond window");

  a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_mode == MODE_TICK) |=> in_stall)
    else $error("tick accepted without input stalling");

endmodule

bind two_line_scrolling_marquee marq_chk #(.WINDOW(WINDOW)) u_marq_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_valid),
  .in_stall     (in_stall),
  .in_mode      (in_mode),
  .out_valid    (out_valid),
  .out_stall    (out_stall),
  .out_line     (out_line),
  .out_column   (out_column),
  .out_char_code(out_char_code),
  .out_set_now  (out_set_now),
  .out_last     (out_last)
);
`default_nettype wire
